@@ rtl/gss_pkg.sv @@
package gss_pkg;

  // Frame geometry limits and reset sizes.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int M_DATA_W   = 32;

  // Kernel weights and the divide-by-100 reciprocal.
  // floor(s * RECIP >> RECIP_SHIFT) equals floor(s / 100) for every s below 2^15.
  localparam int W_CORNER    = 9;
  localparam int W_EDGE      = 12;
  localparam int W_CENTER    = 15;
  localparam int SUM3_W      = 10;
  localparam int SUM_W       = 15;
  localparam int RECIP       = 41944;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = 31;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // Queue between the window front end and the arithmetic back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  // One interior window, reduced to its three weight groups.
  typedef struct packed {
    logic [SUM3_W-1:0] corners;
    logic [SUM3_W-1:0] edges;
    logic [PIX_W-1:0]  center;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } win_item_t;

endpackage

@@ rtl/gss_front.sv @@
module gss_front
  import gss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,
  input  logic [QCNT_W-1:0]     q_count,
  output logic                  push_valid,
  output win_item_t             push_item
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW > WREG_W) ? AW : WREG_W;
  localparam int RST_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // Position of the next incoming pixel and the last column and row of the frame.
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [CW-1:0]    wlast;
  logic [ROW_W-1:0] hlast;

  logic [CW:0]         w_raw;
  logic [CW:0]         w_eff;
  logic [CW-1:0]       wlast_cfg;
  logic [HREG_W-1:0]   h_raw;
  logic [HREG_W-1:0]   h_eff;
  logic [ROW_W-1:0]    hlast_cfg;
  cfg_reg_t            cfg_sel;

  logic                accept;
  logic [QCNT_W:0]     q_used;
  logic [CW-1:0]       col_next;
  logic [ROW_W-1:0]    row_next;
  logic [AW-1:0]       rd_idx;

  // Line stores: line_a holds the previous row, line_b the row before it.
  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_b;

  // Stage after acceptance, while the line stores are read.
  logic             p0_valid;
  logic             p0_emit;
  logic [PIX_W-1:0] p0_pix;
  logic [AW-1:0]    p0_idx;
  logic [ROW_W-1:0] p0_row;
  logic [COL_W-1:0] p0_col;
  logic             p0_last;

  // Window columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom.
  logic [PIX_W-1:0] win [6];

  // Accept a word only when the queue has room for it behind the one in flight.
  assign q_used   = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(p0_valid);
  assign s_tready = q_used < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign rd_idx   = col_cnt[AW-1:0];
  assign cfg_sel  = cfg_reg_t'(cfg_index);

  // Clamp the written sizes into their usable ranges.
  always_comb begin
    w_raw = (CW + 1)'(cfg_data[WREG_W-1:0]);
    if (w_raw < (CW + 1)'(3)) begin
      w_eff = (CW + 1)'(3);
    end else if (w_raw > (CW + 1)'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    wlast_cfg = CW'(w_eff - (CW + 1)'(1));

    h_raw = cfg_data[HREG_W-1:0];
    if (h_raw < HREG_W'(3)) begin
      h_eff = HREG_W'(3);
    end else if (h_raw > HREG_W'(MAX_HEIGHT)) begin
      h_eff = HREG_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    hlast_cfg = ROW_W'(h_eff - HREG_W'(1));
  end

  // Raster position advance with wrap at row and frame end.
  always_comb begin
    if (col_cnt == wlast) begin
      col_next = '0;
      row_next = (row_cnt == hlast) ? '0 : row_cnt + ROW_W'(1);
    end else begin
      col_next = col_cnt + CW'(1);
      row_next = row_cnt;
    end
  end

  // Position counters and size registers; a size write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      wlast   <= CW'(RST_W_EFF - 1);
      hlast   <= ROW_W'(RESET_HEIGHT - 1);
    end else if (cfg_we) begin
      col_cnt <= '0;
      row_cnt <= '0;
      unique case (cfg_sel)
        CFG_WIDTH:  wlast <= wlast_cfg;
        CFG_HEIGHT: hlast <= hlast_cfg;
      endcase
    end else if (accept) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
    end
  end

  // Line store A: read at the incoming column, written with the pixel in flight.
  always_ff @(posedge clk) begin
    rd_a <= line_a[rd_idx];
    if (p0_valid) begin
      line_a[p0_idx] <= p0_pix;
    end
  end

  // Line store B: takes the row that moves out of line store A.
  always_ff @(posedge clk) begin
    rd_b <= line_b[rd_idx];
    if (p0_valid) begin
      line_b[p0_idx] <= rd_a;
    end
  end

  // Capture the accepted pixel and classify it.
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= accept;
    end
    if (accept) begin
      p0_pix  <= s_tdata;
      p0_idx  <= rd_idx;
      p0_emit <= (row_cnt >= ROW_W'(2)) && (col_cnt >= CW'(2));
      p0_row  <= row_cnt - ROW_W'(1);
      p0_col  <= COL_W'(col_cnt - CW'(1));
      p0_last <= (row_cnt == hlast) && (col_cnt == wlast);
    end
  end

  // Window shift by one column per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= '0;
      win[1] <= '0;
      win[2] <= '0;
      win[3] <= '0;
      win[4] <= '0;
      win[5] <= '0;
    end else if (p0_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_b;
      win[4] <= rd_a;
      win[5] <= p0_pix;
    end
  end

  // Group sums of the finished window go to the queue.
  always_comb begin
    push_valid        = p0_valid && p0_emit;
    push_item.corners = SUM3_W'(win[0]) + SUM3_W'(win[2]) + SUM3_W'(rd_b) + SUM3_W'(p0_pix);
    push_item.edges   = SUM3_W'(win[1]) + SUM3_W'(win[3]) + SUM3_W'(win[5]) + SUM3_W'(rd_a);
    push_item.center  = win[4];
    push_item.row     = p0_row;
    push_item.col     = p0_col;
    push_item.last    = p0_last;
  end

  // The raster position never passes the frame edge.
  a_col_bound: assert property (@(posedge clk) disable iff (rst) col_cnt <= wlast)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst) row_cnt <= hlast)
    else $error("row counter beyond frame height");

  // Only interior centers reach the queue.
  a_interior: assert property (@(posedge clk) disable iff (rst)
      push_valid |-> (push_item.row != '0) && $past(accept))
    else $error("window pushed for a border pixel");

endmodule

@@ rtl/gss_fifo.sv @@
module gss_fifo
  import gss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  win_item_t         push_item,
  output logic [QCNT_W-1:0] count,
  output logic              out_valid,
  input  logic              out_ready,
  output win_item_t         out_item
);

  win_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      push |-> count != QCNT_W'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count lost a push");

endmodule

@@ rtl/gss_back.sv @@
module gss_back
  import gss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  win_item_t           in_item,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  // Weighted sum stage.
  logic             a_valid;
  logic [SUM_W-1:0] a_sum;
  logic [ROW_W-1:0] a_row;
  logic [COL_W-1:0] a_col;
  logic             a_last;

  // Reciprocal product stage.
  logic              b_valid;
  logic [PROD_W-1:0] b_prod;
  logic [ROW_W-1:0]  b_row;
  logic [COL_W-1:0]  b_col;
  logic              b_last;

  // Output register.
  logic             o_valid;
  logic [PIX_W-1:0] o_val;
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;
  logic             o_last;

  logic              o_ready;
  logic              b_ready;
  logic              a_ready;
  logic [SUM_W-1:0]  sum;
  logic [QUOT_W-1:0] quot;

  // Each stage moves when the next one is empty or moving.
  assign o_ready  = !o_valid || m_tready;
  assign b_ready  = !b_valid || o_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign sum = SUM_W'(in_item.corners) * SUM_W'(W_CORNER)
             + SUM_W'(in_item.edges) * SUM_W'(W_EDGE)
             + SUM_W'(in_item.center) * SUM_W'(W_CENTER);

  assign quot = b_prod[PROD_W-1:RECIP_SHIFT];

  // Weighted sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_sum  <= sum;
      a_row  <= in_item.row;
      a_col  <= in_item.col;
      a_last <= in_item.last;
    end
  end

  // Divide by 100 as a multiply by its scaled reciprocal.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_prod <= PROD_W'(a_sum) * PROD_W'(RECIP);
      b_row  <= a_row;
      b_col  <= a_col;
      b_last <= a_last;
    end
  end

  // Saturate to 8 bits and hold the word until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= b_valid;
    end
    if (o_ready && b_valid) begin
      o_val  <= (quot > QUOT_W'(255)) ? PIX_W'(255) : quot[PIX_W-1:0];
      o_row  <= b_row;
      o_col  <= b_col;
      o_last <= b_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_col, o_row, o_val};
  assign m_tlast  = o_last;

endmodule

@@ rtl/gauss_smooth_3x3_stream.sv @@
// A pixel passes a capture register, the queue, then sum, product and output registers.
// Throughput: one pixel per cycle sustained; a pixel is taken while results wait, and
// input stalls only when the 4-entry divide queue, counting the pixel in flight, is full.
// Reset: position returns to row 0, column 0, frame size to 640 x 480, window to zero;
// the line stores are not cleared and no startup pass is needed.
module gauss_smooth_3x3_stream
  import gss_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] gray_pixel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [7:0] smoothed_value, [19:8] center_row,
                                           // [30:20] center_col, [31] zero
  output logic                  m_tlast    // frame_last
);

  logic              push_valid;
  win_item_t         push_item;
  logic [QCNT_W-1:0] q_count;
  logic              q_valid;
  logic              q_ready;
  win_item_t         q_item;

  // Line buffers, window and raster position.
  gss_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Decoupling queue.
  gss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_item (push_item),
    .count     (q_count),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Weighted sum, divide and saturate.
  gss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_item  (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import gss_pkg::*;

  // One smoothed word as the block should deliver it.
  typedef struct {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } smooth_word_t;

  // Pixel content patterns for a run of words.
  typedef enum int {
    PIX_UNIFORM,
    PIX_BRIGHT,
    PIX_DARK,
    PIX_EXTREME,
    PIX_SAT,
    PIX_ZERO,
    PIX_CHECKER
  } pix_mode_t;

  // Tracks frame position, line stores and window, and queues the smoothed words owed.
  class smooth_scoreboard;
    logic [PIX_W-1:0]  prev_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  older_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win [6];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    smooth_word_t      owed_q[$];
    int unsigned       mismatches;

    function new();
      foreach (prev_line[i]) begin
        prev_line[i] = '0;
        older_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = WREG_W'(RESET_WIDTH);
      height_reg = HREG_W'(RESET_HEIGHT);
      mismatches = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // Any register write restarts the frame; stored lines are kept.
    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WIDTH) width_reg = data[WREG_W-1:0];
      else height_reg = data[HREG_W-1:0];
      row_pos = 0;
      col_pos = 0;
    endfunction

    // Called for every accepted pixel word.
    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned  w;
      int unsigned  h;
      int unsigned  corners;
      int unsigned  edges;
      int unsigned  total;
      int unsigned  quot;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      smooth_word_t res;
      w = eff_width();
      h = eff_height();
      top = older_line[col_pos];
      mid = prev_line[col_pos];
      if (row_pos >= 2 && col_pos >= 2) begin
        corners = win[0] + win[2] + top + pix;
        edges = win[1] + win[3] + win[5] + mid;
        total = 9 * corners + 12 * edges + 15 * win[4];
        quot = total / 100;
        if (quot > 255) quot = 255;
        res.value = quot[PIX_W-1:0];
        res.row = ROW_W'(row_pos - 1);
        res.col = COL_W'(col_pos - 1);
        res.last = (row_pos == h - 1) && (col_pos == w - 1);
        owed_q.push_back(res);
      end
      older_line[col_pos] = mid;
      prev_line[col_pos] = pix;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    // Compares one delivered word with the oldest owed one.
    function void check_result(logic [M_DATA_W-1:0] data, logic last);
      smooth_word_t exp_w;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word data=%h last=%b", data, last);
        return;
      end
      exp_w = owed_q.pop_front();
      if (data[7:0] !== exp_w.value || data[19:8] !== exp_w.row ||
          data[30:20] !== exp_w.col || data[31] !== 1'b0 || last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: got value=%0d row=%0d col=%0d pad=%b last=%b, want value=%0d row=%0d col=%0d last=%b",
                   data[7:0], data[19:8], data[30:20], data[31], last,
                   exp_w.value, exp_w.row, exp_w.col, exp_w.last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;   // [7:0] gray_pixel
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;   // [7:0] smoothed_value, [19:8] center_row,
                                    // [30:20] center_col, [31] zero
  logic                  m_tlast;   // frame_last

  smooth_scoreboard sb = new();
  int unsigned      idle_pct;
  int unsigned      sent_words;

  gauss_smooth_3x3_stream dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Clock: 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Output side back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Every accepted output word is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // Drives one pixel word, with random gaps ahead of it.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(pix);
  endtask

  // Drives a run of pixel words following one content pattern.
  task automatic send_run(input int unsigned count, input pix_mode_t mode);
    logic [PIX_W-1:0] pix;
    for (int unsigned i = 0; i < count; i++) begin
      case (mode)
        PIX_BRIGHT:  pix = PIX_W'($urandom_range(200, 255));
        PIX_DARK:    pix = PIX_W'($urandom_range(0, 15));
        PIX_EXTREME: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_SAT:     pix = 8'hFF;
        PIX_ZERO:    pix = 8'h00;
        PIX_CHECKER: pix = i[0] ? 8'hFF : 8'h00;
        default:     pix = PIX_W'($urandom_range(0, 255));
      endcase
      send_pixel(pix);
    end
    sent_words += count;
  endtask

  // Stops the input, drains every owed word and lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Writes one register once the block is idle.
  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random geometry and content, mostly small frames.
  task automatic random_phase();
    int unsigned sel;
    int unsigned area;
    int unsigned count;
    logic [CFG_DATA_W-1:0] wval;
    logic [CFG_DATA_W-1:0] hval;
    sel = $urandom_range(0, 99);
    if (sel < 85) wval = CFG_DATA_W'($urandom_range(3, 24));
    else if (sel < 96) wval = CFG_DATA_W'($urandom_range(0, 2));
    else wval = CFG_DATA_W'($urandom_range(0, 8191));
    sel = $urandom_range(0, 99);
    if (sel < 85) hval = CFG_DATA_W'($urandom_range(3, 12));
    else if (sel < 96) hval = CFG_DATA_W'($urandom_range(0, 2));
    else hval = CFG_DATA_W'($urandom_range(0, 8191));
    case ($urandom_range(0, 3))
      0: begin
        write_cfg(CFG_WIDTH, wval);
        write_cfg(CFG_HEIGHT, hval);
      end
      1: write_cfg(CFG_HEIGHT, hval);
      2: write_cfg(CFG_WIDTH, wval);
      default: drain();
    endcase
    area = sb.eff_width() * sb.eff_height();
    if (area > 600) count = $urandom_range(1, 300);
    else if ($urandom_range(0, 9) < 7) count = area * $urandom_range(1, 2);
    else count = $urandom_range(1, 2 * area);
    // Keep the total of all runs within their word budget.
    if (count > 1500 - sent_words) count = 1500 - sent_words;
    idle_pct = ($urandom_range(0, 7) == 0) ? 0 : 32;
    send_run(count, pix_mode_t'($urandom_range(PIX_UNIFORM, PIX_EXTREME)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    idle_pct = 32;
    sent_words = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry of 640 x 480: two full rows and the start of the third.
    send_run(2 * RESET_WIDTH + 4, PIX_UNIFORM);

    // Smallest frame, sizes below range clamp to 3: saturation, zero, checkerboard.
    write_cfg(CFG_WIDTH, 13'd0);
    write_cfg(CFG_HEIGHT, 13'd1);
    send_run(9, PIX_SAT);
    send_run(9, PIX_ZERO);
    send_run(9, PIX_CHECKER);

    // Width with all bits set clamps to the widest frame; a short run of the first row.
    write_cfg(CFG_WIDTH, 13'h1FFF);
    send_run(12, PIX_UNIFORM);

    // Narrow frame with the height clamped to its maximum, no idling on either side.
    idle_pct = 0;
    write_cfg(CFG_WIDTH, 13'd6);
    write_cfg(CFG_HEIGHT, 13'h1FFF);
    send_run(96, PIX_UNIFORM);

    idle_pct = 32;
    while (sent_words < 1450) random_phase();

    idle_pct = 32;
    drain();
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
